// File: rtl/utce_pkg.sv
// Shared constants, types and helper functions for the UTC time string converter.
`default_nettype none

package utce_pkg;

    localparam int CHAR_W      = 8;
    localparam int YEAR_W      = 12;
    localparam int FIELD_W     = 7;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = 4;
    localparam int EPOCH_W     = 40;
    localparam int DAYS_W      = 23;
    localparam int HMS_W       = 19;
    localparam int DOE_W       = 18;

    localparam logic [CNT_W-1:0] MAX_CHARS   = 4'd12;
    localparam logic [CNT_W-1:0] FIELD_CHARS = 4'd12;
    localparam logic [CNT_W-1:0] COUNT_SAT   = 4'd13;
    localparam logic [CNT_W-1:0] MIN_CHARS   = 4'd2;
    localparam logic [CNT_W-1:0] MONTH_CHARS = 4'd4;

    localparam logic [YEAR_W-1:0] YEAR_RESET = 12'd2000;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

    // Multiplier constants (operand b of the shared unit)
    localparam logic [17:0] RECIP_100      = 18'd5243;    // x/100 = (x*5243) >> 19
    localparam logic [17:0] RECIP_400      = 18'd5243;    // x/400 = (x*5243) >> 21
    localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
    localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [17:0] SECS_PER_HOUR  = 18'd3600;
    localparam logic [17:0] SECS_PER_DAY   = 18'd86400;
    localparam logic [19:0] EPOCH_DAY_OFFSET = 20'd719468;

    localparam logic signed [14:0] WINDOW  = 15'sd50;
    localparam logic signed [14:0] CENTURY = 15'sd100;
    localparam logic signed [14:0] ERA_BIAS = 15'sd400;

    typedef enum logic [3:0] {
        CALC_IDLE,
        CALC_CENT,
        CALC_YEAR,
        CALC_ERA,
        CALC_YOE,
        CALC_C100,
        CALC_DOE,
        CALC_DAYS,
        CALC_HMS,
        CALC_TOTAL
    } calc_state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] year_offset;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
    } utce_fields_t;

    typedef struct packed {
        logic busy;
        logic done;
    } utce_status_t;

    // Day of year at the first of a March-based month (0 = March)
    function automatic logic [8:0] doy_of(input logic [3:0] mp);
        logic [8:0] d;
        begin
            case (mp)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd61;
                4'd3:    d = 9'd92;
                4'd4:    d = 9'd122;
                4'd5:    d = 9'd153;
                4'd6:    d = 9'd184;
                4'd7:    d = 9'd214;
                4'd8:    d = 9'd245;
                4'd9:    d = 9'd275;
                4'd10:   d = 9'd306;
                4'd11:   d = 9'd337;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

    // Quotient by twelve for values 0..98
    function automatic logic [3:0] div12(input logic [FIELD_W-1:0] x);
        logic [12:0] p;
        begin
            p = {6'b0, x} * 13'd43;
            return p[12:9];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/utce_if.sv
// Channel interfaces: characters in, epoch results out, reference year writes.
`default_nettype none

interface utce_char_if;
    logic                         valid;
    logic                         ready;
    logic [utce_pkg::CHAR_W-1:0]  char_code;
    logic                         last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface utce_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [utce_pkg::EPOCH_W-1:0] epoch_seconds;
    logic                                parse_failed;

    modport source (output valid, epoch_seconds, parse_failed, input ready);
    modport sink   (input valid, epoch_seconds, parse_failed, output ready);
endinterface

interface utce_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [utce_pkg::YEAR_W-1:0]  reference_year;

    modport source (output valid, reference_year, input ready);
    modport sink   (input valid, reference_year, output ready);
endinterface

`default_nettype wire

// File: rtl/utctime_string_to_epoch_top.sv
// Top level: YYMMDDhhmmss character stream to Unix epoch seconds.
//
// chars  : one ASCII character per beat, last_char marks the end of a string.
// result : one beat per string, epoch_seconds (signed, UTC) and parse_failed.
// cfg    : writes reference_year, the year two-digit years are windowed around
//          (within fifty years). Write only while no string is in flight.
// Ordinary characters are taken one per cycle while chars is ready, and produce no beat.
// A marked character that fails the format check (length, non-digit, month 00)
// gives its result in the cycle after it is taken, with epoch_seconds zero.
// A good string enters the conversion sequencer, which steps through CENT, YEAR,
// ERA, YOE, C100, DOE, DAYS, HMS and TOTAL around the shared multiply-add unit;
// the result is registered as TOTAL ends. chars is held off while the sequencer
// is busy, so one string is converted at a time.
// A result waiting on a stalled receiver holds; chars stays ready only while
// the result register is empty or being drained.
// Reset clears the string state and the result valid flag and sets the
// reference year to 2000.
`default_nettype none

module utctime_string_to_epoch_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    utce_char_if.sink     chars,
    utce_result_if.source result,
    utce_cfg_if.sink      cfg
);

    logic [utce_pkg::YEAR_W-1:0]  reference_year_reg;

    logic [utce_pkg::CNT_W-1:0]   char_count_reg;
    logic [utce_pkg::CNT_W-1:0]   char_count_next;
    logic [utce_pkg::DIGIT_W-1:0] pending_digit_reg;
    logic [utce_pkg::DIGIT_W-1:0] pending_digit_next;
    logic                         bad_pair_reg;
    logic                         bad_pair_next;
    utce_pkg::utce_fields_t       fields_reg;
    utce_pkg::utce_fields_t       fields_next;

    logic                                result_valid_reg;
    logic signed [utce_pkg::EPOCH_W-1:0] epoch_reg;
    logic                                failed_reg;

    utce_pkg::utce_status_t              calc_status;
    logic signed [utce_pkg::EPOCH_W-1:0] calc_total;

    logic                         char_accept;
    logic                         is_digit;
    logic [utce_pkg::DIGIT_W-1:0] digit;
    logic [utce_pkg::FIELD_W-1:0] pair_value;
    logic                         fail_now;
    logic                         calc_start;
    logic                         clear_string;

    assign cfg.ready   = 1'b1;
    assign chars.ready = !calc_status.busy && (!result_valid_reg || result.ready);
    assign char_accept = chars.valid && chars.ready;

    assign is_digit   = (chars.char_code >= utce_pkg::ASCII_ZERO)
                     && (chars.char_code <= utce_pkg::ASCII_NINE);
    assign digit      = is_digit ? 4'(chars.char_code - utce_pkg::ASCII_ZERO) : '0;
    assign pair_value = {pending_digit_reg, 3'b0} + {2'b0, pending_digit_reg, 1'b0}
                      + {3'b0, digit};

    always_comb
    begin
        pending_digit_next = pending_digit_reg;
        bad_pair_next      = bad_pair_reg;
        fields_next        = fields_reg;
        char_count_next    = char_count_reg;
        if (char_count_reg < utce_pkg::FIELD_CHARS)
        begin
            if (!is_digit)
            begin
                bad_pair_next = 1'b1;
            end
            if (!char_count_reg[0])
            begin
                pending_digit_next = digit;
            end
            else
            begin
                case (char_count_reg[3:1])
                    3'd0:    fields_next.year_offset = pair_value;
                    3'd1:    fields_next.month       = pair_value;
                    3'd2:    fields_next.day         = pair_value;
                    3'd3:    fields_next.hour        = pair_value;
                    3'd4:    fields_next.minute      = pair_value;
                    default: fields_next.second      = pair_value;
                endcase
            end
        end
        if (char_count_reg < utce_pkg::COUNT_SAT)
        begin
            char_count_next = char_count_reg + 4'd1;
        end
    end

    assign fail_now = (char_count_next < utce_pkg::MIN_CHARS)
                   || (char_count_next > utce_pkg::MAX_CHARS)
                   || char_count_next[0]
                   || bad_pair_next
                   || ((char_count_next >= utce_pkg::MONTH_CHARS) && (fields_next.month == '0));

    assign calc_start   = char_accept && chars.last_char && !fail_now;
    assign clear_string = (char_accept && chars.last_char && fail_now) || calc_status.done;

    utce_calc u_calc (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (calc_start),
        .reference_year (reference_year_reg),
        .fields         (fields_reg),
        .status         (calc_status),
        .total          (calc_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_year_reg <= utce_pkg::YEAR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            reference_year_reg <= cfg.reference_year;
        end
    end

    // String state: accumulate on each beat, drop back to defaults once consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg         <= '0;
            pending_digit_reg      <= '0;
            bad_pair_reg           <= 1'b0;
            fields_reg.year_offset <= '0;
            fields_reg.month       <= 7'd1;
            fields_reg.day         <= 7'd1;
            fields_reg.hour        <= '0;
            fields_reg.minute      <= '0;
            fields_reg.second      <= '0;
        end
        else if (clear_string)
        begin
            char_count_reg         <= '0;
            pending_digit_reg      <= '0;
            bad_pair_reg           <= 1'b0;
            fields_reg.year_offset <= '0;
            fields_reg.month       <= 7'd1;
            fields_reg.day         <= 7'd1;
            fields_reg.hour        <= '0;
            fields_reg.minute      <= '0;
            fields_reg.second      <= '0;
        end
        else if (char_accept)
        begin
            char_count_reg    <= char_count_next;
            pending_digit_reg <= pending_digit_next;
            bad_pair_reg      <= bad_pair_next;
            fields_reg        <= fields_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if ((char_accept && chars.last_char && fail_now) || calc_status.done)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_status.done)
        begin
            epoch_reg  <= calc_total;
            failed_reg <= 1'b0;
        end
        else if (char_accept && chars.last_char && fail_now)
        begin
            epoch_reg  <= '0;
            failed_reg <= 1'b1;
        end
    end

    assign result.valid         = result_valid_reg;
    assign result.epoch_seconds = epoch_reg;
    assign result.parse_failed  = failed_reg;

    // The result register must be empty when the sequencer finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        calc_status.done |-> !result_valid_reg)
    else $error("conversion finished while a result was still pending");

    // A good string takes a fixed walk through the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        calc_start |-> ##9 calc_status.done)
    else $error("conversion did not finish on schedule");

    // A rejected string reports zero seconds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && failed_reg) |-> (epoch_reg == '0))
    else $error("failed result carries nonzero seconds");

    // No character is taken while the sequencer runs
    assert property (@(posedge clk) disable iff (!rst_n)
        calc_start |=> !chars.ready)
    else $error("character accepted during conversion");

endmodule

`default_nettype wire

// File: rtl/utce_calc.sv
// Calendar-to-seconds sequencer built around one shared multiply-add unit.
`default_nettype none

module utce_calc (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [utce_pkg::YEAR_W-1:0]          reference_year,
    input  wire utce_pkg::utce_fields_t               fields,
    output utce_pkg::utce_status_t                    status,
    output logic signed [utce_pkg::EPOCH_W-1:0]       total
);

    utce_pkg::calc_state_t state_reg;
    utce_pkg::calc_state_t state_next;

    logic [5:0]                         cent_reg;
    logic [12:0]                        yy400_reg;
    logic [3:0]                         mp_reg;
    logic [3:0]                         era1_reg;
    logic [8:0]                         yoe_reg;
    logic [1:0]                         c100_reg;
    logic [utce_pkg::DOE_W-1:0]         doe_reg;
    logic signed [utce_pkg::DAYS_W-1:0] days_reg;
    logic [utce_pkg::HMS_W-1:0]         hms_reg;

    // Shared multiplier
    logic signed [23:0] mul_a;
    logic [17:0]        mul_b;
    logic signed [42:0] prod;

    assign prod = mul_a * $signed({1'b0, mul_b});

    // Year windowing and month carry
    logic [12:0]                 cent_base;
    logic signed [14:0]          year_raw;
    logic signed [14:0]          year_diff;
    logic signed [14:0]          year_win;
    logic [utce_pkg::FIELD_W-1:0] mon0;
    logic [3:0]                  mon_carry;
    logic [6:0]                  mon_carry12;
    logic [3:0]                  mon_idx;
    logic signed [14:0]          year_adj;
    logic signed [14:0]          yy;
    logic signed [14:0]          yy400;
    logic [3:0]                  mp;

    assign cent_base = {1'b0, cent_reg, 6'b0} + {2'b0, cent_reg, 5'b0} + {5'b0, cent_reg, 2'b0};
    assign year_raw  = $signed({2'b0, cent_base}) + $signed({8'b0, fields.year_offset});
    assign year_diff = year_raw - $signed({3'b0, reference_year});

    always_comb
    begin
        if (year_diff > utce_pkg::WINDOW)
        begin
            year_win = year_raw - utce_pkg::CENTURY;
        end
        else if (year_diff < -utce_pkg::WINDOW)
        begin
            year_win = year_raw + utce_pkg::CENTURY;
        end
        else
        begin
            year_win = year_raw;
        end
    end

    assign mon0        = fields.month - 7'd1;
    assign mon_carry   = utce_pkg::div12(mon0);
    assign mon_carry12 = {mon_carry, 3'b0} + {1'b0, mon_carry, 2'b0};
    assign mon_idx     = 4'(mon0 - mon_carry12);
    assign year_adj    = year_win + $signed({11'b0, mon_carry});
    // January and February count in the previous March-based year
    assign yy          = (mon_idx < 4'd2) ? year_adj - 15'sd1 : year_adj;
    assign yy400       = yy + utce_pkg::ERA_BIAS;
    assign mp          = (mon_idx < 4'd2) ? mon_idx + 4'd10 : mon_idx - 4'd2;

    // Year of era
    logic [12:0] era400;
    logic [12:0] yoe_full;

    assign era400   = {1'b0, era1_reg, 8'b0} + {2'b0, era1_reg, 7'b0} + {5'b0, era1_reg, 4'b0};
    assign yoe_full = yy400_reg - era400;

    // Day of era, day count, seconds within the day
    logic [utce_pkg::DOE_W-1:0]         doe_sum;
    logic signed [utce_pkg::DAYS_W-1:0] days_sum;
    logic [12:0]                        min_secs;
    logic [utce_pkg::HMS_W-1:0]         hms_sum;
    logic signed [42:0]                 total_sum;

    assign doe_sum  = prod[utce_pkg::DOE_W-1:0] + {11'b0, yoe_reg[8:2]} - {16'b0, c100_reg}
                    + {9'b0, utce_pkg::doy_of(mp_reg)};
    assign days_sum = $signed(prod[utce_pkg::DAYS_W-1:0]) + $signed({5'b0, doe_reg})
                    - $signed({3'b0, utce_pkg::EPOCH_DAY_OFFSET})
                    + $signed({16'b0, fields.day}) - 23'sd1;
    assign min_secs = {fields.minute, 6'b0} - {4'b0, fields.minute, 2'b0};
    assign hms_sum  = prod[utce_pkg::HMS_W-1:0] + {6'b0, min_secs} + {12'b0, fields.second};
    assign total_sum = prod + $signed({24'b0, hms_reg});
    assign total     = total_sum[utce_pkg::EPOCH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= utce_pkg::CALC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mul_a       = '0;
        mul_b       = '0;
        status.busy = (state_reg != utce_pkg::CALC_IDLE);
        status.done = 1'b0;
        case (state_reg)
            utce_pkg::CALC_IDLE:
            begin
                if (start)
                begin
                    state_next = utce_pkg::CALC_CENT;
                end
            end
            utce_pkg::CALC_CENT:
            begin
                mul_a      = $signed({12'b0, reference_year});
                mul_b      = utce_pkg::RECIP_100;
                state_next = utce_pkg::CALC_YEAR;
            end
            utce_pkg::CALC_YEAR:
            begin
                state_next = utce_pkg::CALC_ERA;
            end
            utce_pkg::CALC_ERA:
            begin
                mul_a      = $signed({11'b0, yy400_reg});
                mul_b      = utce_pkg::RECIP_400;
                state_next = utce_pkg::CALC_YOE;
            end
            utce_pkg::CALC_YOE:
            begin
                state_next = utce_pkg::CALC_C100;
            end
            utce_pkg::CALC_C100:
            begin
                mul_a      = $signed({15'b0, yoe_reg});
                mul_b      = utce_pkg::RECIP_100;
                state_next = utce_pkg::CALC_DOE;
            end
            utce_pkg::CALC_DOE:
            begin
                mul_a      = $signed({15'b0, yoe_reg});
                mul_b      = utce_pkg::DAYS_PER_YEAR;
                state_next = utce_pkg::CALC_DAYS;
            end
            utce_pkg::CALC_DAYS:
            begin
                mul_a      = $signed({20'b0, era1_reg}) - 24'sd1;
                mul_b      = utce_pkg::DAYS_PER_ERA;
                state_next = utce_pkg::CALC_HMS;
            end
            utce_pkg::CALC_HMS:
            begin
                mul_a      = $signed({17'b0, fields.hour});
                mul_b      = utce_pkg::SECS_PER_HOUR;
                state_next = utce_pkg::CALC_TOTAL;
            end
            utce_pkg::CALC_TOTAL:
            begin
                mul_a       = $signed({days_reg[utce_pkg::DAYS_W-1], days_reg});
                mul_b       = utce_pkg::SECS_PER_DAY;
                status.done = 1'b1;
                state_next  = utce_pkg::CALC_IDLE;
            end
            default:
            begin
                state_next = utce_pkg::CALC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            utce_pkg::CALC_CENT:
            begin
                cent_reg <= prod[24:19];
            end
            utce_pkg::CALC_YEAR:
            begin
                yy400_reg <= yy400[12:0];
                mp_reg    <= mp;
            end
            utce_pkg::CALC_ERA:
            begin
                era1_reg <= prod[24:21];
            end
            utce_pkg::CALC_YOE:
            begin
                yoe_reg <= yoe_full[8:0];
            end
            utce_pkg::CALC_C100:
            begin
                c100_reg <= prod[20:19];
            end
            utce_pkg::CALC_DOE:
            begin
                doe_reg <= doe_sum;
            end
            utce_pkg::CALC_DAYS:
            begin
                days_reg <= days_sum;
            end
            utce_pkg::CALC_HMS:
            begin
                hms_reg <= hms_sum;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
